/* design/sarr_pkg.sv */
// Shared types, constants and a helper function of the sensor alert scheduler.
package sarr_pkg;

    localparam int QUEUE_SLOTS = 4;
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
    localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

    localparam int SENSORS   = 4;
    localparam int SENSOR_W  = 2;
    localparam int PRESS_W   = 16;
    localparam int ENTRY_W   = SENSOR_W + PRESS_W;
    localparam int TRACK_W   = 5;
    localparam int OCC_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [TRACK_W-1:0] TRK_ANNOUNCE  = 5'd14;
    localparam logic [TRACK_W-1:0] TRK_HIGH_BASE = 5'd18;
    localparam logic [TRACK_W-1:0] TRK_LOW_BASE  = 5'd22;
    localparam logic [TRACK_W-1:0] TRK_LEAK_BASE = 5'd26;
    localparam logic [TRACK_W-1:0] TRK_MAX       = 5'd26;
    localparam logic [TRACK_W-1:0] VOICE_SHIFT   = 5'd13;

    localparam logic [PRESS_W-1:0] WAIT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_POLL = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH    = 3'd0,
        CFG_LOW     = 3'd1,
        CFG_LEAK    = 3'd2,
        CFG_TIMEOUT = 3'd3,
        CFG_MALE    = 3'd4,
        CFG_VOICE   = 3'd5
    } t_cfg_idx;

    // The male voice set holds the same phrases thirteen tracks lower.
    function automatic logic [TRACK_W-1:0] map_voice(input logic [TRACK_W-1:0] t,
                                                     input logic male);
        logic [TRACK_W-1:0] res;
        res = t;
        if (male && t >= TRK_ANNOUNCE && t <= TRK_MAX) begin
            res = t - VOICE_SHIFT;
        end
        return res;
    endfunction

endpackage

/* design/sarr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module sarr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sarr_track.sv */
// Pressure classification into alert tracks, followed by the voice mapping.
module sarr_track (
    input  logic [sarr_pkg::PRESS_W-1:0]  i_pressure,
    input  logic [sarr_pkg::SENSOR_W-1:0] i_sensor,
    input  logic [sarr_pkg::PRESS_W-1:0]  i_high,
    input  logic [sarr_pkg::PRESS_W-1:0]  i_low,
    input  logic [sarr_pkg::PRESS_W-1:0]  i_leak,
    input  logic                          i_male,
    output logic [sarr_pkg::TRACK_W-1:0]  o_track,
    output logic                          o_hit
);
    import sarr_pkg::*;

    logic [TRACK_W-1:0] raw;
    logic [TRACK_W-1:0] sens_ext;

    assign sens_ext = TRACK_W'(i_sensor);

    // High is tested first, then low, then the leak band above the low limit.
    always_comb begin
        raw = '0;
        if (i_pressure > i_high) begin
            raw = TRK_HIGH_BASE - sens_ext;
        end else if (i_pressure < i_low) begin
            raw = TRK_LOW_BASE - sens_ext;
        end else if (i_pressure < i_leak && i_pressure > i_low) begin
            raw = TRK_LEAK_BASE - sens_ext;
        end
    end

    assign o_hit   = (raw != '0);
    assign o_track = map_voice(raw, i_male);

endmodule

/* design/sensor_alert_round_robin_scheduler.sv */
// Top level of the sensor alert scheduler: sequencer, slot memory and configuration.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         start high, busy low       i_req_type, i_sensor_id, i_pressure
//   result    out        o_done, one cycle          o_track_valid, o_track, o_dropped,
//                                                   o_occupancy
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// One transaction is worked on at a time. A tick or an unused request code goes from
// acceptance straight to the decision state, which sets the registered result strobe.
// An add or a poll first scans the slot memory, one read per slot, then decides: an
// add finishes there. A poll that serves an entry reads that slot again for its
// pressure, in a fetch state and then a serve state, before the strobe.
// Reset is synchronous and active low; it clears the valid bits, the wait state, the
// seen mask and the configuration to its defaults. The slot memory itself is not
// cleared: a slot's contents are only used while its valid bit is set. The receiver
// cannot stall, so every result strobe is shown for exactly one cycle.
module sensor_alert_round_robin_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic [sarr_pkg::SENSOR_W-1:0]   i_sensor_id,
    input  logic [sarr_pkg::PRESS_W-1:0]    i_pressure,
    // Result channel.
    output logic                            o_done,
    output logic                            o_track_valid,
    output logic [sarr_pkg::TRACK_W-1:0]    o_track,
    output logic                            o_dropped,
    output logic [sarr_pkg::OCC_W-1:0]      o_occupancy,
    // Configuration port.
    input  logic                            i_cfg_we,
    input  logic [sarr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sarr_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import sarr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_FETCH  = 5'b01000,
        S_SERVE  = 5'b10000
    } t_state;

    // Control state.
    t_state                 r_state, n_state;
    logic [QUEUE_SLOTS-1:0] r_valid, n_valid;
    logic [SENSOR_W-1:0]    r_wait, n_wait;
    logic [PRESS_W-1:0]     r_wcnt, n_wcnt;
    logic [SENSORS-1:0]     r_seen, n_seen;
    logic                   r_alerts, n_alerts;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_rd_vld, n_rd_vld;

    // Configuration registers.
    logic [PRESS_W-1:0]     r_high, r_low, r_leak, r_tmo;
    logic                   r_male, r_von;

    // Transaction payload and scan results.
    t_req                   r_req, n_req;
    logic [SENSOR_W-1:0]    r_sid, n_sid;
    logic [PRESS_W-1:0]     r_prs, n_prs;
    logic [SLOT_W-1:0]      r_rd_idx, n_rd_idx;
    logic [SENSORS-1:0]     r_present, n_present;
    logic [SLOT_W-1:0]      r_idx_of [SENSORS];
    logic [SLOT_W-1:0]      r_srv_idx, n_srv_idx;

    // Result registers.
    logic                   r_track_valid, n_track_valid;
    logic [TRACK_W-1:0]     r_track, n_track;
    logic                   r_dropped, n_dropped;
    logic [OCC_W-1:0]       r_occ, n_occ;

    // Slot memory port.
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [SENSOR_W-1:0]    rd_sensor;

    // Decision helpers.
    logic                   any_free;
    logic [SLOT_W-1:0]      first_free;
    logic                   rr_found;
    logic [SENSOR_W-1:0]    rr_sensor;
    logic [SENSOR_W-1:0]    sel_sensor;
    logic [SLOT_W-1:0]      sel_idx;
    logic                   fin;
    logic                   idx_we;

    // Track unit outputs.
    logic [TRACK_W-1:0]     trk_track;
    logic                   trk_hit;

    // Each entry holds the sensor in its upper bits and the pressure below.
    sarr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_sensor = ram_rdata[PRESS_W +: SENSOR_W];

    sarr_track u_track (
        .i_pressure (ram_rdata[PRESS_W-1:0]),
        .i_sensor   (rd_sensor),
        .i_high     (r_high),
        .i_low      (r_low),
        .i_leak     (r_leak),
        .i_male     (r_male),
        .o_track    (trk_track),
        .o_hit      (trk_hit)
    );

    // Lowest free slot, taken from the valid bits without touching the memory.
    always_comb begin
        any_free   = 1'b0;
        first_free = '0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                any_free   = 1'b1;
                first_free = SLOT_W'(i);
            end
        end
    end

    // Round robin search: the first present sensor after the awaited one. Four steps
    // cover every sensor, the awaited one last.
    always_comb begin
        logic [SENSOR_W-1:0] cand;
        rr_found  = 1'b0;
        rr_sensor = r_wait;
        for (int k = SENSORS - 1; k >= 1; k--) begin
            cand = r_wait + SENSOR_W'(k);
            if (r_present[cand]) begin
                rr_found  = 1'b1;
                rr_sensor = cand;
            end
        end
        if (!rr_found && r_present[r_wait]) begin
            rr_found  = 1'b1;
            rr_sensor = r_wait;
        end
    end

    // The slot of the sensor that an add replaces or a poll serves.
    always_comb begin
        if (r_req == REQ_ADD) begin
            sel_sensor = r_sid;
        end else if (r_present[r_wait]) begin
            sel_sensor = r_wait;
        end else begin
            sel_sensor = rr_sensor;
        end
    end

    assign sel_idx = r_idx_of[sel_sensor];

    // Sequencer. Only one transaction is in flight, so every write to the memory lands
    // before the next scan reads it: the sequencer itself is the interlock.
    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_wait        = r_wait;
        n_wcnt        = r_wcnt;
        n_seen        = r_seen;
        n_alerts      = r_alerts;
        n_done        = 1'b0;
        n_cnt         = r_cnt;
        n_rd_vld      = 1'b0;
        n_req         = r_req;
        n_sid         = r_sid;
        n_prs         = r_prs;
        n_rd_idx      = r_rd_idx;
        n_present     = r_present;
        n_srv_idx     = r_srv_idx;
        n_track_valid = r_track_valid;
        n_track       = r_track;
        n_dropped     = r_dropped;
        n_occ         = r_occ;
        ram_we        = 1'b0;
        ram_waddr     = first_free;
        ram_wdata     = {r_sid, r_prs};
        ram_re        = 1'b0;
        ram_raddr     = r_cnt[SLOT_W-1:0];
        idx_we        = 1'b0;
        fin           = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = t_req'(i_req_type);
                    n_sid     = i_sensor_id;
                    n_prs     = i_pressure;
                    n_present = '0;
                    n_cnt     = '0;
                    if (t_req'(i_req_type) == REQ_ADD || t_req'(i_req_type) == REQ_POLL) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_SCAN: begin
                // Reads are issued back to back; each one is sorted in the cycle after it is issued.
                if (r_cnt != CNT_W'(QUEUE_SLOTS)) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[SLOT_W-1:0];
                    n_cnt    = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_DECIDE;
                end
                if (r_rd_vld && r_valid[r_rd_idx]) begin
                    n_present[rd_sensor] = 1'b1;
                    idx_we               = 1'b1;
                end
            end

            S_DECIDE: begin
                case (r_req)
                    REQ_ADD: begin
                        n_seen[r_sid] = 1'b1;
                        fin           = 1'b1;
                        if (r_present[r_sid]) begin
                            ram_we     = 1'b1;
                            ram_waddr  = sel_idx;
                            n_valid[sel_idx] = 1'b1;
                        end else if (any_free) begin
                            ram_we     = 1'b1;
                            ram_waddr  = first_free;
                            n_valid[first_free] = 1'b1;
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                    REQ_POLL: begin
                        if (!r_alerts && r_seen == '1) begin
                            // The announcement plays once if the voice is on, and serves nothing.
                            n_alerts = 1'b1;
                            fin      = 1'b1;
                            if (r_von) begin
                                n_track_valid = 1'b1;
                                n_track       = map_voice(TRK_ANNOUNCE, r_male);
                            end
                        end else if (r_valid == '0) begin
                            n_wait = '0;
                            n_wcnt = '0;
                            fin    = 1'b1;
                        end else if (r_present[r_wait] || r_wcnt >= r_tmo) begin
                            // The queue is not empty, so the round robin search hits.
                            n_wcnt    = '0;
                            n_srv_idx = sel_idx;
                            n_state   = S_FETCH;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    REQ_TICK: begin
                        if (r_wcnt != WAIT_MAX) begin
                            n_wcnt = r_wcnt + PRESS_W'(1);
                        end
                        fin = 1'b1;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_srv_idx;
                n_state   = S_SERVE;
            end

            S_SERVE: begin
                // Before the announcement an entry is still removed, but stays silent.
                n_valid[r_srv_idx] = 1'b0;
                n_wait             = rd_sensor + SENSOR_W'(1);
                n_wcnt             = '0;
                fin                = 1'b1;
                if (r_alerts && trk_hit && r_von) begin
                    n_track_valid = 1'b1;
                    n_track       = trk_track;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
            n_occ   = '0;
            for (int i = 0; i < QUEUE_SLOTS; i++) begin
                n_occ = n_occ + OCC_W'(n_valid[i]);
            end
        end

        // Result fields read as zero unless this transaction sets them.
        if (r_state == S_IDLE && start) begin
            n_track_valid = 1'b0;
            n_track       = '0;
            n_dropped     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_wait   <= '0;
            r_wcnt   <= '0;
            r_seen   <= '0;
            r_alerts <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_wait   <= n_wait;
            r_wcnt   <= n_wcnt;
            r_seen   <= n_seen;
            r_alerts <= n_alerts;
            r_done   <= n_done;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= 16'd300;
            r_low  <= 16'd200;
            r_leak <= 16'd230;
            r_tmo  <= 16'd20000;
            r_male <= 1'b0;
            r_von  <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HIGH:    r_high <= i_cfg_wdata;
                CFG_LOW:     r_low  <= i_cfg_wdata;
                CFG_LEAK:    r_leak <= i_cfg_wdata;
                CFG_TIMEOUT: r_tmo  <= i_cfg_wdata;
                CFG_MALE:    r_male <= i_cfg_wdata[0];
                CFG_VOICE:   r_von  <= i_cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_sid         <= n_sid;
        r_prs         <= n_prs;
        r_rd_idx      <= n_rd_idx;
        r_present     <= n_present;
        r_srv_idx     <= n_srv_idx;
        r_track_valid <= n_track_valid;
        r_track       <= n_track;
        r_dropped     <= n_dropped;
        r_occ         <= n_occ;
        if (idx_we) begin
            r_idx_of[rd_sensor] <= r_rd_idx;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_track_valid = r_track_valid;
    assign o_track       = r_track;
    assign o_dropped     = r_dropped;
    assign o_occupancy   = r_occ;

    // An accepted transaction always keeps the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    // The reported occupancy matches the valid bits it was taken from.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_occupancy == OCC_W'($countones(r_valid))))
        else $error("occupancy disagrees with the valid bits");

    // A dropped add never plays a track.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_dropped |-> !o_track_valid)
        else $error("dropped add issued a track");

    // The pressure fetch is always followed by the serve step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_SERVE))
        else $error("fetch not followed by serve");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sensor alert round robin scheduler.
module testbench;
    import sarr_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int IDLE_PCT       = 22;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    // Longest path through the block: slot scan, decision and the pressure re-read.
    localparam int SETTLE_CYCLES  = QUEUE_SLOTS + 5;
    localparam int TMO_TICKS      = 12;

    // One scheduler response as it appears on the result ports.
    typedef struct packed {
        logic               track_valid;
        logic [TRACK_W-1:0] track;
        logic               dropped;
        logic [OCC_W-1:0]   occupancy;
    } t_sched_response;

    // Ports of the block. Every input holds a known value from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type  = '0;
    logic [SENSOR_W-1:0]  i_sensor_id = '0;
    logic [PRESS_W-1:0]   i_pressure  = '0;
    logic                 o_done;
    logic                 o_track_valid;
    logic [TRACK_W-1:0]   o_track;
    logic                 o_dropped;
    logic [OCC_W-1:0]     o_occupancy;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    // Shadow copy of the scheduler: slot memory, round robin state and registers.
    logic                slot_used  [QUEUE_SLOTS];
    logic [SENSOR_W-1:0] slot_id    [QUEUE_SLOTS];
    logic [PRESS_W-1:0]  slot_press [QUEUE_SLOTS];
    logic [SENSOR_W-1:0] awaited;
    logic [PRESS_W-1:0]  tick_count;
    logic [SENSORS-1:0]  seen;
    logic                alerts_live;
    logic [PRESS_W-1:0]  high_lim, low_lim, leak_lim, timeout_ticks;
    logic                male_set, voice_set;

    // Responses predicted for accepted transactions, oldest first.
    t_sched_response due_responses[$];

    bit gaps_on = 1'b1;
    int mismatches;
    int responses_checked;
    int tracks_due;
    int rr_moves;
    int req_count [4];
    int idle_cycles;

    sensor_alert_round_robin_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_sensor_id   (i_sensor_id),
        .i_pressure    (i_pressure),
        .o_done        (o_done),
        .o_track_valid (o_track_valid),
        .o_track       (o_track),
        .o_dropped     (o_dropped),
        .o_occupancy   (o_occupancy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int find_slot(logic [SENSOR_W-1:0] sid);
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == sid) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int occupied();
        int n;
        n = 0;
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (slot_used[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // The male voice set sits thirteen tracks below the female one.
    function automatic logic [TRACK_W-1:0] voiced(logic [TRACK_W-1:0] t);
        if (male_set && t >= TRK_ANNOUNCE && t <= TRK_MAX) begin
            return t - VOICE_SHIFT;
        end
        return t;
    endfunction

    // Applies one transaction to the shadow state and returns the response it causes.
    function automatic t_sched_response next_response(t_req req, logic [SENSOR_W-1:0] sid,
                                                      logic [PRESS_W-1:0] prs);
        t_sched_response     resp;
        int                  idx;
        logic [SENSOR_W-1:0] s;
        logic [TRACK_W-1:0]  t;
        resp = '0;
        req_count[req]++;
        case (req)
            REQ_ADD: begin
                // Replace the sensor's own entry, else take the lowest free slot.
                idx = find_slot(sid);
                seen[sid] = 1'b1;
                if (idx < 0) begin
                    for (int i = 0; i < QUEUE_SLOTS; i++) begin
                        if (!slot_used[i] && idx < 0) begin
                            idx = i;
                        end
                    end
                end
                if (idx >= 0) begin
                    slot_used[idx]  = 1'b1;
                    slot_id[idx]    = sid;
                    slot_press[idx] = prs;
                end else begin
                    resp.dropped = 1'b1;
                end
            end
            REQ_TICK: begin
                if (tick_count != WAIT_MAX) begin
                    tick_count++;
                end
            end
            REQ_POLL: begin
                if (!alerts_live && seen == '1) begin
                    // The start-up announcement comes once and serves nothing.
                    alerts_live = 1'b1;
                    if (voice_set) begin
                        resp.track_valid = 1'b1;
                        resp.track       = voiced(TRK_ANNOUNCE);
                    end
                end else if (occupied() == 0) begin
                    awaited    = '0;
                    tick_count = '0;
                end else begin
                    idx = find_slot(awaited);
                    if (idx >= 0) begin
                        tick_count = '0;
                    end else if (tick_count >= timeout_ticks) begin
                        tick_count = '0;
                        rr_moves++;
                        for (int k = 0; k < 5 && idx < 0; k++) begin
                            awaited = awaited + 1'b1;
                            idx     = find_slot(awaited);
                        end
                    end
                    if (idx >= 0) begin
                        s = slot_id[idx];
                        t = '0;
                        if (alerts_live) begin
                            if (slot_press[idx] > high_lim) begin
                                t = TRK_HIGH_BASE - {3'b000, s};
                            end else if (slot_press[idx] < low_lim) begin
                                t = TRK_LOW_BASE - {3'b000, s};
                            end else if (slot_press[idx] < leak_lim &&
                                         slot_press[idx] > low_lim) begin
                                t = TRK_LEAK_BASE - {3'b000, s};
                            end
                        end
                        if (t != '0 && voice_set) begin
                            resp.track_valid = 1'b1;
                            resp.track       = voiced(t);
                        end
                        slot_used[idx] = 1'b0;
                        awaited        = s + 1'b1;
                        tick_count     = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        resp.occupancy = OCC_W'(occupied());
        if (resp.track_valid) begin
            tracks_due++;
        end
        return resp;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one transaction and records its predicted response on acceptance.
    // In each cycle the sender may idle at random, so pauses also fall where the
    // block is ready. Start is left high; the next call or idle period decides it.
    task automatic send_item(t_req req, logic [SENSOR_W-1:0] sid, logic [PRESS_W-1:0] prs);
        bit sent;
        sent = 1'b0;
        while (!sent) begin
            @(negedge i_clk);
            start       <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            i_req_type  <= req;
            i_sensor_id <= sid;
            i_pressure  <= prs;
            @(posedge i_clk);
            sent = (start === 1'b1 && busy === 1'b0);
        end
        due_responses.push_back(next_response(req, sid, prs));
    endtask

    // Holds off new transactions until every predicted response has been seen.
    task automatic wait_until_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_responses.size() != 0 || busy !== 1'b0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HIGH:    high_lim      = val;
            CFG_LOW:     low_lim       = val;
            CFG_LEAK:    leak_lim      = val;
            CFG_TIMEOUT: timeout_ticks = val;
            CFG_MALE:    male_set      = val[0];
            CFG_VOICE:   voice_set     = val[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking: every strobe is matched against the oldest prediction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_sched_response want;
        if (i_rst_n && o_done === 1'b1) begin
            responses_checked++;
            if (due_responses.size() == 0) begin
                report_mismatch($sformatf("%0t: result strobe with no transaction outstanding",
                                          $time));
            end else begin
                want = due_responses.pop_front();
                if (o_track_valid !== want.track_valid || o_track !== want.track ||
                    o_dropped !== want.dropped || o_occupancy !== want.occupancy) begin
                    report_mismatch({
                        $sformatf("%0t: expected valid=%0b track=%0d dropped=%0b occ=%0d",
                                  $time, want.track_valid, want.track, want.dropped,
                                  want.occupancy),
                        $sformatf(", got valid=%0b track=%0d dropped=%0b occ=%0d",
                                  o_track_valid, o_track, o_dropped, o_occupancy)});
                end
            end
        end
    end

    // The watchdog counts cycles in which no transaction, result or write goes through.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d responses outstanding",
                     idle_cycles, due_responses.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The unused request code only reports occupancy; a poll of the empty queue
    // clears the wait state; a tick just counts.
    task automatic test_unused_and_empty();
        send_item(REQ_NONE, 2'd3, 16'hFFFF);
        send_item(REQ_POLL, 2'd0, 16'h0000);
        send_item(REQ_TICK, 2'd0, 16'h0000);
    endtask

    // Before the announcement a poll still removes the entry it serves, but stays silent.
    task automatic test_muted_serving();
        send_item(REQ_ADD, 2'd0, 16'hFFFF);
        send_item(REQ_POLL, 2'd0, 16'h0000);
    endtask

    // Once all four sensors have been seen the next poll announces; then the leak and
    // low bands are served in round robin order, with pressures that fall in no band
    // and a replaced entry among them.
    task automatic test_announcement_and_tracks();
        send_item(REQ_ADD, 2'd1, 16'd0);
        send_item(REQ_ADD, 2'd1, 16'd250);
        send_item(REQ_ADD, 2'd2, 16'd210);
        send_item(REQ_ADD, 2'd3, 16'd300);
        send_item(REQ_ADD, 2'd0, 16'd199);
        send_item(REQ_POLL, 2'd0, 16'd0);
        repeat (4) send_item(REQ_POLL, 2'd0, 16'd0);
        // Sensor 1 is awaited but absent, and the timeout is far away: nothing moves.
        send_item(REQ_ADD, 2'd3, 16'd301);
        send_item(REQ_POLL, 2'd0, 16'd0);
        send_item(REQ_TICK, 2'd0, 16'd0);
        send_item(REQ_POLL, 2'd0, 16'd0);
    endtask

    // Male voice shifts the track down; voice off silences a served alert.
    task automatic test_voice_settings();
        wait_until_idle();
        write_reg(CFG_MALE, 16'd1);
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(REQ_TICK, 2'd0, 16'd0);
        send_item(REQ_POLL, 2'd0, 16'd0);
        wait_until_idle();
        write_reg(CFG_VOICE, 16'd0);
        send_item(REQ_ADD, 2'd1, 16'd0);
        send_item(REQ_TICK, 2'd0, 16'd0);
        send_item(REQ_POLL, 2'd0, 16'd0);
        wait_until_idle();
        write_reg(CFG_VOICE, 16'd1);
        write_reg(CFG_MALE, 16'd0);
    endtask

    // With a zero timeout an absent awaited sensor is skipped at once.
    task automatic test_zero_timeout();
        write_reg(CFG_TIMEOUT, 16'd0);
        send_item(REQ_ADD, 2'd0, 16'hFFFF);
        send_item(REQ_ADD, 2'd3, 16'd220);
        send_item(REQ_POLL, 2'd0, 16'd0);
        send_item(REQ_POLL, 2'd0, 16'd0);
    endtask

    // The awaited sensor stays absent: one tick short of the timeout a poll serves
    // nothing, and the tick that reaches it lets the next poll move on.
    task automatic test_timeout_boundary();
        gaps_on = 1'b0;
        while (occupied() != 0) begin
            send_item(REQ_POLL, 2'd0, 16'd0);
        end
        send_item(REQ_POLL, 2'd0, 16'd0);
        wait_until_idle();
        write_reg(CFG_TIMEOUT, CFG_W'(TMO_TICKS));
        send_item(REQ_ADD, 2'd1, 16'd100);
        repeat (TMO_TICKS - 1) send_item(REQ_TICK, 2'd2, 16'hA5A5);
        send_item(REQ_POLL, 2'd0, 16'd0);
        send_item(REQ_TICK, 2'd0, 16'd0);
        send_item(REQ_POLL, 2'd0, 16'd0);
        gaps_on = 1'b1;
    endtask

    // One phase of random traffic under a fixed register setting. Pressures are
    // mostly drawn near the current limits so that every band edge gets hit.
    task automatic random_phase(int n, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] lo,
                                logic [CFG_W-1:0] leak, logic [CFG_W-1:0] tmo,
                                logic male, logic voice);
        int                  pick;
        t_req                req;
        logic [SENSOR_W-1:0] sid;
        logic [PRESS_W-1:0]  prs;
        wait_until_idle();
        write_reg(CFG_HIGH, hi);
        write_reg(CFG_LOW, lo);
        write_reg(CFG_LEAK, leak);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MALE, {15'd0, male});
        write_reg(CFG_VOICE, {15'd0, voice});
        repeat (n) begin
            pick = $urandom_range(0, 99);
            sid  = SENSOR_W'($urandom_range(0, SENSORS - 1));
            case ($urandom_range(0, 5))
                0: prs = PRESS_W'($urandom);
                1: prs = high_lim + PRESS_W'($urandom_range(0, 2)) - 16'd1;
                2: prs = low_lim + PRESS_W'($urandom_range(0, 2)) - 16'd1;
                3: prs = leak_lim + PRESS_W'($urandom_range(0, 2)) - 16'd1;
                4: prs = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: prs = low_lim + PRESS_W'($urandom_range(0, 40));
            endcase
            if (pick < 40) begin
                req = REQ_ADD;
            end else if (pick < 70) begin
                req = REQ_POLL;
            end else if (pick < 96) begin
                req = REQ_TICK;
            end else begin
                req = REQ_NONE;
            end
            send_item(req, sid, prs);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] lo;
        random_phase(110, 16'd300, 16'd200, 16'd230, 16'd3, 1'b0, 1'b1);
        lo = CFG_W'($urandom_range(100, 250));
        random_phase(110, CFG_W'($urandom_range(250, 400)), lo,
                     lo + CFG_W'($urandom_range(0, 60)),
                     CFG_W'($urandom_range(1, 8)), 1'b1, 1'b1);
        lo = CFG_W'($urandom);
        random_phase(70, CFG_W'($urandom), lo, lo + CFG_W'($urandom_range(0, 500)),
                     16'd2, 1'b0, 1'b0);
        // Extreme limits: nonzero pressures are high, or all but 0 and FFFF are leaks.
        random_phase(80, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1, 1'b1);
        random_phase(80, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 1'b0, 1'b1);
        // A long stretch with the sender never pausing.
        gaps_on = 1'b0;
        random_phase(150, 16'd300, 16'd200, 16'd230, 16'd4, 1'b0, 1'b1);
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial begin
        // Shadow state and registers start at their reset values.
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_id[i]    = '0;
            slot_press[i] = '0;
        end
        awaited       = '0;
        tick_count    = '0;
        seen          = '0;
        alerts_live   = 1'b0;
        high_lim      = 16'd300;
        low_lim       = 16'd200;
        leak_lim      = 16'd230;
        timeout_ticks = 16'd20000;
        male_set      = 1'b0;
        voice_set     = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unused_and_empty();
        test_muted_serving();
        test_announcement_and_tracks();
        test_voice_settings();
        test_zero_timeout();
        test_timeout_boundary();
        test_random_traffic();

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d add, %0d poll, %0d tick, %0d unused-code transactions",
                 req_count[REQ_ADD], req_count[REQ_POLL], req_count[REQ_TICK],
                 req_count[REQ_NONE]);
        $display("summary: %0d responses checked, %0d tracks, %0d round robin moves",
                 responses_checked, tracks_due, rr_moves);
        $display("summary: %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sensor_alert_round_robin_scheduler.f */
design/sarr_pkg.sv
design/sarr_ram.sv
design/sarr_track.sv
design/sensor_alert_round_robin_scheduler.sv
verif/testbench.sv
